[sv/ddm_pkg.sv]
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared widths, register map and serial multiply-divide control types for
// the differential drive mixer.
// ----------------------------------------------------------------------------
package ddm_pkg;

  localparam int SPD_W   = 16;   // Q11.4 speeds and errors
  localparam int DRV_W   = 11;   // signed drive command
  localparam int LIM_W   = 15;   // slew limits and tolerances
  localparam int MAXD_W  = 10;   // min_drive and max_drive
  localparam int SIDE_W  = 14;   // signed side value after dead-band push
  localparam int MAG_W   = 13;   // magnitude of a side value
  localparam int PROD_W  = MAG_W + MAXD_W;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [DRV_W-1:0]  DRIVE_LIMIT = 11'd1023;
  localparam logic [MAXD_W-1:0] MIN_DRIVE_RST = 10'd0;
  localparam logic [MAXD_W-1:0] MAX_DRIVE_RST = 10'd255;
  localparam logic [LIM_W-1:0]  DIST_SLEW_RST = 15'd320;
  localparam logic [LIM_W-1:0]  ROT_SLEW_RST  = 15'd160;
  localparam logic [LIM_W-1:0]  DIST_TOL_RST  = 15'd8;
  localparam logic [LIM_W-1:0]  ROT_TOL_RST   = 15'd8;

  typedef enum logic [2:0] {
    REG_MIN_DRIVE  = 3'd0,
    REG_MAX_DRIVE  = 3'd1,
    REG_DIST_SLEW  = 3'd2,
    REG_ROT_SLEW   = 3'd3,
    REG_DIST_TOL   = 3'd4,
    REG_ROT_TOL    = 3'd5
  } ddm_reg_t;

  // request to the serial multiply-divide unit: q = a * m / d
  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  a;
    logic [MAXD_W-1:0] m;
    logic [MAG_W-1:0]  d;
  } ddm_md_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] q;
  } ddm_md_rsp_t;

endpackage

[sv/ddm_if.sv]
// ----------------------------------------------------------------------------
// ddm_in_if / ddm_out_if
// Valid/ready channels carrying the controller inputs and the drive results.
// ----------------------------------------------------------------------------
interface ddm_in_if;
  import ddm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SPD_W-1:0] dist_speed;
  logic signed [SPD_W-1:0] rot_speed;
  logic signed [SPD_W-1:0] dist_error;
  logic signed [SPD_W-1:0] rot_error;

  modport source (output valid, dist_speed, rot_speed, dist_error, rot_error,
                  input ready);
  modport sink   (input valid, dist_speed, rot_speed, dist_error, rot_error,
                  output ready);
endinterface

interface ddm_out_if;
  import ddm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] left_drive;
  logic signed [DRV_W-1:0] right_drive;
  logic                    arrived;

  modport source (output valid, left_drive, right_drive, arrived, input ready);
  modport sink   (input valid, left_drive, right_drive, arrived, output ready);
endinterface

[sv/diff_drive_mixer_slew_limit_core.sv]
// ----------------------------------------------------------------------------
// diff_drive_mixer_slew_limit_core
// Differential drive mixer with slew limit, dead-band push and rescaling.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. An arrival result goes from
// ST_TOL straight to ST_OUT; a result without rescaling passes ST_SLEW,
// ST_HOLD, ST_MIX, ST_PUSH, ST_OFS and ST_CHK; a rescaled result also waits
// in ST_DIV, where the two serial multiply-divide units take 10 multiply
// steps and 23 quotient steps, one bit each per cycle, and set the rate of
// the block when rescaling is needed. in_ch.ready rises once the previous
// result has been moved into the output register, even while that result
// still waits on out_ch.ready; no new input is taken before that.
// Configuration registers sit at byte addresses 0, 4, .. 20 of the APB port.
module diff_drive_mixer_slew_limit_core (
  input  logic                       clk,
  input  logic                       rst_n,
  ddm_in_if.sink                     in_ch,
  ddm_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ddm_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [ddm_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [ddm_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import ddm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TOL, ST_SLEW, ST_HOLD, ST_MIX, ST_PUSH, ST_OFS, ST_CHK,
    ST_DIV, ST_OUT
  } state_t;

  // configuration registers
  logic [MAXD_W-1:0] min_drive_r, max_drive_r;
  logic [LIM_W-1:0]  dist_slew_r, rot_slew_r, dist_tol_r, rot_tol_r;
  ddm_reg_t          reg_sel;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = ddm_reg_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_drive_r <= MIN_DRIVE_RST;
      max_drive_r <= MAX_DRIVE_RST;
      dist_slew_r <= DIST_SLEW_RST;
      rot_slew_r  <= ROT_SLEW_RST;
      dist_tol_r  <= DIST_TOL_RST;
      rot_tol_r   <= ROT_TOL_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MIN_DRIVE: min_drive_r <= cfg_pwdata[MAXD_W-1:0];
        REG_MAX_DRIVE: max_drive_r <= cfg_pwdata[MAXD_W-1:0];
        REG_DIST_SLEW: dist_slew_r <= cfg_pwdata[LIM_W-1:0];
        REG_ROT_SLEW:  rot_slew_r  <= cfg_pwdata[LIM_W-1:0];
        REG_DIST_TOL:  dist_tol_r  <= cfg_pwdata[LIM_W-1:0];
        REG_ROT_TOL:   rot_tol_r   <= cfg_pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_DRIVE: cfg_prdata = DATA_W'(min_drive_r);
      REG_MAX_DRIVE: cfg_prdata = DATA_W'(max_drive_r);
      REG_DIST_SLEW: cfg_prdata = DATA_W'(dist_slew_r);
      REG_ROT_SLEW:  cfg_prdata = DATA_W'(rot_slew_r);
      REG_DIST_TOL:  cfg_prdata = DATA_W'(dist_tol_r);
      REG_ROT_TOL:   cfg_prdata = DATA_W'(rot_tol_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // clamp target - held to +-lim
  function automatic logic signed [SPD_W-1:0] slew_delta(
    input logic signed [SPD_W-1:0] target,
    input logic signed [SPD_W-1:0] held,
    input logic        [LIM_W-1:0] lim
  );
    logic signed [SPD_W:0] d;
    logic signed [SPD_W:0] pl;
    logic signed [SPD_W:0] nl;
    d  = {target[SPD_W-1], target} - {held[SPD_W-1], held};
    pl = $signed({2'b00, lim});
    nl = -pl;
    if (d > pl) d = pl;
    if (d < nl) d = nl;
    return d[SPD_W-1:0];
  endfunction

  // saturate a side value into the drive range
  function automatic logic signed [DRV_W-1:0] sat_side(
    input logic signed [SIDE_W-1:0] v
  );
    logic signed [SIDE_W-1:0] hi;
    hi = $signed({{(SIDE_W-DRV_W){1'b0}}, DRIVE_LIMIT});
    if (v > hi) return DRIVE_LIMIT;
    if (v < -hi) return -DRIVE_LIMIT;
    return v[DRV_W-1:0];
  endfunction

  // signed result from a quotient magnitude
  function automatic logic signed [DRV_W-1:0] sat_quot(
    input logic [MAG_W-1:0] q,
    input logic             neg
  );
    logic [DRV_W-1:0] m;
    m = (q > MAG_W'(DRIVE_LIMIT)) ? DRIVE_LIMIT : q[DRV_W-1:0];
    return neg ? -m : m;
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] u;
    u = v[SIDE_W-1] ? -v : v;
    return u[MAG_W-1:0];
  endfunction

  state_t                   state_r;
  logic signed [SPD_W-1:0]  ds_r, rs_r, de_r, re_r;
  logic signed [SPD_W-1:0]  held_d_r, held_r_r;
  logic signed [SPD_W-1:0]  dd_r, dr_r;
  logic signed [SPD_W:0]    sum_l_r, sum_r_r;
  logic signed [SIDE_W-1:0] left_r, right_r;
  logic signed [DRV_W-1:0]  res_l_r, res_r_r;
  logic                     res_arr_r;
  logic signed [DRV_W-1:0]  out_l_r, out_r_r;
  logic                     out_arr_r, out_valid_r;
  ddm_md_req_t              req_l_r, req_r_r;
  ddm_md_rsp_t              rsp_l, rsp_r;

  ddm_muldiv u_md_left  (.clk(clk), .rst_n(rst_n), .req(req_l_r), .rsp(rsp_l));
  ddm_muldiv u_md_right (.clk(clk), .rst_n(rst_n), .req(req_r_r), .rsp(rsp_r));

  logic [SPD_W:0]           ade, are;
  logic                     near;
  logic signed [SPD_W:0]    rnd_l, rnd_r;
  logic signed [SIDE_W-1:0] whole_l, whole_r;
  logic signed [SIDE_W-1:0] mx, mn;
  logic                     pos_hit, neg_hit;
  logic signed [SIDE_W-1:0] side_max, side_min, side_negmin;
  logic                     out_free;

  always_comb begin
    ade  = de_r[SPD_W-1] ? ((SPD_W+1)'(0) - {1'b1, de_r}) : {1'b0, de_r};
    are  = re_r[SPD_W-1] ? ((SPD_W+1)'(0) - {1'b1, re_r}) : {1'b0, re_r};
    near = (ade < {2'b00, dist_tol_r}) && (are < {2'b00, rot_tol_r});
    // divide by 16 toward zero
    rnd_l   = sum_l_r + (sum_l_r[SPD_W] ? (SPD_W+1)'(15) : '0);
    rnd_r   = sum_r_r + (sum_r_r[SPD_W] ? (SPD_W+1)'(15) : '0);
    whole_l = SIDE_W'(rnd_l >>> 4);
    whole_r = SIDE_W'(rnd_r >>> 4);
    mx      = $signed({{(SIDE_W-MAXD_W){1'b0}}, max_drive_r});
    mn      = $signed({{(SIDE_W-MAXD_W){1'b0}}, min_drive_r});
    pos_hit = (left_r >= mx) || (right_r >= mx);
    neg_hit = (left_r <= -mx) || (right_r <= -mx);
    side_max    = (left_r > right_r) ? left_r : right_r;
    side_min    = (left_r < right_r) ? left_r : right_r;
    side_negmin = -side_min;
    out_free    = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      held_d_r      <= '0;
      held_r_r      <= '0;
      out_valid_r   <= 1'b0;
      req_l_r.start <= 1'b0;
      req_r_r.start <= 1'b0;
    end else begin
      req_l_r.start <= 1'b0;
      req_r_r.start <= 1'b0;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            ds_r    <= in_ch.dist_speed;
            rs_r    <= in_ch.rot_speed;
            de_r    <= in_ch.dist_error;
            re_r    <= in_ch.rot_error;
            state_r <= ST_TOL;
          end
        end
        ST_TOL: begin
          if (near) begin
            res_l_r   <= '0;
            res_r_r   <= '0;
            res_arr_r <= 1'b1;
            state_r   <= ST_OUT;
          end else begin
            res_arr_r <= 1'b0;
            state_r   <= ST_SLEW;
          end
        end
        ST_SLEW: begin
          dd_r    <= slew_delta(ds_r, held_d_r, dist_slew_r);
          dr_r    <= slew_delta(rs_r, held_r_r, rot_slew_r);
          state_r <= ST_HOLD;
        end
        ST_HOLD: begin
          held_d_r <= held_d_r + dd_r;
          held_r_r <= held_r_r + dr_r;
          state_r  <= ST_MIX;
        end
        ST_MIX: begin
          sum_l_r <= {held_d_r[SPD_W-1], held_d_r} + {held_r_r[SPD_W-1], held_r_r};
          sum_r_r <= {held_d_r[SPD_W-1], held_d_r} - {held_r_r[SPD_W-1], held_r_r};
          state_r <= ST_PUSH;
        end
        ST_PUSH: begin
          left_r  <= whole_l;
          right_r <= whole_r;
          state_r <= ST_OFS;
        end
        ST_OFS: begin
          // zero sum counts as non-positive
          left_r  <= (sum_l_r > 0) ? left_r + mn : left_r - mn;
          right_r <= (sum_r_r > 0) ? right_r + mn : right_r - mn;
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (max_drive_r == '0) begin
            res_l_r <= '0;
            res_r_r <= '0;
            state_r <= ST_OUT;
          end else if (pos_hit || neg_hit) begin
            req_l_r.start <= 1'b1;
            req_l_r.a     <= mag(left_r);
            req_l_r.m     <= max_drive_r;
            req_l_r.d     <= pos_hit ? side_max[MAG_W-1:0] : side_negmin[MAG_W-1:0];
            req_r_r.start <= 1'b1;
            req_r_r.a     <= mag(right_r);
            req_r_r.m     <= max_drive_r;
            req_r_r.d     <= pos_hit ? side_max[MAG_W-1:0] : side_negmin[MAG_W-1:0];
            state_r       <= ST_DIV;
          end else begin
            res_l_r <= sat_side(left_r);
            res_r_r <= sat_side(right_r);
            state_r <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (rsp_l.done && rsp_r.done) begin
            res_l_r <= sat_quot(rsp_l.q, left_r[SIDE_W-1]);
            res_r_r <= sat_quot(rsp_r.q, right_r[SIDE_W-1]);
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_l_r     <= res_l_r;
            out_r_r     <= res_r_r;
            out_arr_r   <= res_arr_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_drive  = out_l_r;
  assign out_ch.right_drive = out_r_r;
  assign out_ch.arrived     = out_arr_r;

endmodule

[sv/ddm_muldiv.sv]
// ----------------------------------------------------------------------------
// ddm_muldiv
// Bit-serial unsigned multiply then restoring divide: q = a * m / d.
// One multiplier bit per cycle, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddm_muldiv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddm_pkg::ddm_md_req_t req,
  output ddm_pkg::ddm_md_rsp_t rsp
);
  import ddm_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} md_state_t;

  md_state_t         state_r;
  logic [MAG_W-1:0]  a_r;
  logic [MAXD_W-1:0] m_r;
  logic [MAG_W-1:0]  d_r;
  logic [PROD_W-1:0] acc_r;
  logic [MAG_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;

  logic [PROD_W-1:0] add_nxt;
  logic [MAG_W:0]    trial;
  logic              ge;
  logic [MAG_W:0]    diff;

  always_comb begin
    add_nxt = {acc_r[PROD_W-2:0], 1'b0} + (m_r[MAXD_W-1] ? PROD_W'(a_r) : '0);
    trial   = {rem_r, acc_r[PROD_W-1]};
    ge      = trial >= {1'b0, d_r};
    diff    = trial - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            a_r     <= req.a;
            m_r     <= req.m;
            d_r     <= req.d;
            acc_r   <= '0;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_r <= add_nxt;
          m_r   <= {m_r[MAXD_W-2:0], 1'b0};
          if (cnt_r == CNT_W'(MAXD_W - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          acc_r <= {acc_r[PROD_W-2:0], ge};
          if (cnt_r == CNT_W'(PROD_W - 1)) begin
            cnt_r   <= '0;
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // quotient never exceeds the dividend side magnitude since d >= m
  assign rsp.done = done_r;
  assign rsp.q    = acc_r[MAG_W-1:0];

endmodule
